@@ rtl/integer_to_radix_digits_assert.svh @@
// Assertion shorthands for the radix conversion block.
// Both sample on the rising clock and are off while reset is high.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication.
`define ITRD_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itrd check failed");

// Next-cycle implication.
`define ITRD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itrd check failed");

`endif

@@ rtl/itrd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

   localparam int IN_WIDTH    = 64;
   localparam int RADIX_WIDTH = 8;
   localparam int CHAR_WIDTH  = 7;
   localparam int DIGIT_WIDTH = 6;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 8'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 8'd36;

   localparam logic [CHAR_WIDTH-1:0] ERROR_CHAR  = 7'd0;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LETTER = 7'd55;   // 'A' minus ten

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } itrd_state_type;

   typedef struct packed {
      logic                   radix_error;
      logic [DIGIT_WIDTH-1:0] radix;
   } itrd_cmd_type;

   // Map a digit value to its ASCII code; values past 'Z' fall back to '0'.
   function automatic logic [CHAR_WIDTH-1:0] glyph(input logic [DIGIT_WIDTH-1:0] value);
      logic [CHAR_WIDTH-1:0] wide;
      wide = {1'b0, value};
      if (value < 6'd10) begin
         return CHAR_ZERO + wide;
      end else if (value < 6'd36) begin
         return CHAR_LETTER + wide;
      end
      return CHAR_ZERO;
   endfunction

endpackage

`default_nettype wire

@@ rtl/itrd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itrd_front #(
   parameter int NUMBER_WIDTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [itrd_pkg::IN_WIDTH-1:0]      req_number_value,
   input  wire logic [itrd_pkg::RADIX_WIDTH-1:0]   req_radix,
   output logic                                    q_valid,
   input  wire logic                               q_take,
   output logic [NUMBER_WIDTH-1:0]                 q_number,
   output itrd_pkg::itrd_cmd_type                  q_cmd
);

   logic [NUMBER_WIDTH-1:0] num_ff [2];
   itrd_pkg::itrd_cmd_type  cmd_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              fill_ff, fill_in;
   logic                    push;
   logic                    pop;
   itrd_pkg::itrd_cmd_type  cmd_new;

   // classify the radix on the way in
   always_comb begin
      cmd_new.radix_error = (req_radix < itrd_pkg::RADIX_MIN) ||
                            (req_radix > itrd_pkg::RADIX_MAX);
      cmd_new.radix       = req_radix[itrd_pkg::DIGIT_WIDTH-1:0];
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_number  = num_ff[rd_ptr_ff];
   assign q_cmd     = cmd_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         num_ff[wr_ptr_ff] <= req_number_value[NUMBER_WIDTH-1:0];
         cmd_ff[wr_ptr_ff] <= cmd_new;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/itrd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itrd_back #(
   parameter int NUMBER_WIDTH = 64,
   parameter int MAX_DIGITS   = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   output logic                                   q_take,
   input  wire logic [NUMBER_WIDTH-1:0]           q_number,
   input  wire itrd_pkg::itrd_cmd_type            q_cmd,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [itrd_pkg::CHAR_WIDTH-1:0]        rsp_digit_char,
   output logic                                   rsp_last_digit,
   output logic                                   rsp_radix_error
);

   localparam int BIT_W = $clog2(NUMBER_WIDTH);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int DW    = itrd_pkg::DIGIT_WIDTH;

   itrd_pkg::itrd_state_type state_ff, state_in;

   logic [NUMBER_WIDTH-1:0]         quo_ff, quo_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [DW-1:0]                   radix_ff, radix_in;
   logic [BIT_W-1:0]                bit_ff, bit_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [IDX_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [DW-1:0]                   rd_data_ff;
   logic [itrd_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            err_ff, err_in;

   logic [DW-1:0]                   digit_store [MAX_DIGITS];

   logic [DW:0]                     rem_shift;
   logic [DW:0]                     rem_diff;
   logic                            sub_ok;
   logic [DW-1:0]                   rem_step;
   logic [NUMBER_WIDTH-1:0]         quo_step;
   logic                            bit_last;
   logic [CNT_W-1:0]                count_inc;
   logic                            conv_done;
   logic                            store_wr;

   // one restoring division step per cycle
   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, radix_ff};
      sub_ok    = (rem_shift >= {1'b0, radix_ff});
      rem_step  = sub_ok ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
      quo_step  = {quo_ff[NUMBER_WIDTH-2:0], sub_ok};
      bit_last  = (bit_ff == BIT_W'(NUMBER_WIDTH - 1));
      count_inc = count_ff + CNT_W'(1);
      conv_done = (quo_step == '0) || (count_inc == CNT_W'(MAX_DIGITS));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = q_cmd.radix_error ? itrd_pkg::ST_SEND : itrd_pkg::ST_DIVIDE;
            end
         end
         itrd_pkg::ST_DIVIDE: begin
            if (bit_last && conv_done) begin
               state_in = itrd_pkg::ST_READ;
            end
         end
         itrd_pkg::ST_READ: state_in = itrd_pkg::ST_LOAD;
         itrd_pkg::ST_LOAD: state_in = itrd_pkg::ST_SEND;
         itrd_pkg::ST_SEND: begin
            if (!rsp_stall) begin
               state_in = last_ff ? itrd_pkg::ST_IDLE : itrd_pkg::ST_READ;
            end
         end
         default: state_in = itrd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_take    = 1'b0;
      rsp_valid = 1'b0;
      store_wr  = 1'b0;
      unique case (state_ff)
         itrd_pkg::ST_IDLE:   q_take    = q_valid;
         itrd_pkg::ST_DIVIDE: store_wr  = bit_last;
         itrd_pkg::ST_SEND:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      radix_in  = radix_ff;
      bit_in    = bit_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      err_in    = err_ff;
      case (state_ff)
         itrd_pkg::ST_IDLE: begin
            if (q_valid) begin
               quo_in   = q_number;
               radix_in = q_cmd.radix;
               rem_in   = '0;
               bit_in   = '0;
               count_in = '0;
               char_in  = itrd_pkg::ERROR_CHAR;
               last_in  = 1'b1;
               err_in   = 1'b1;
            end
         end
         itrd_pkg::ST_DIVIDE: begin
            quo_in = quo_step;
            rem_in = rem_step;
            bit_in = bit_ff + BIT_W'(1);
            if (bit_last) begin
               rem_in   = '0;
               bit_in   = '0;
               count_in = count_inc;
               if (conv_done) begin
                  rd_idx_in = count_ff[IDX_W-1:0];
               end
            end
         end
         itrd_pkg::ST_LOAD: begin
            char_in = itrd_pkg::glyph(rd_data_ff);
            last_in = (rd_idx_ff == '0);
            err_in  = 1'b0;
         end
         itrd_pkg::ST_SEND: begin
            if (!rsp_stall && !last_ff) begin
               rd_idx_in = rd_idx_ff - IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         digit_store[count_ff[IDX_W-1:0]] <= rem_step;
      end
      rd_data_ff <= digit_store[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      radix_ff  <= radix_in;
      bit_ff    <= bit_in;
      rd_idx_ff <= rd_idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
      if (reset) begin
         state_ff <= itrd_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign rsp_digit_char  = char_ff;
   assign rsp_last_digit  = last_ff;
   assign rsp_radix_error = err_ff;

endmodule

`default_nettype wire

@@ rtl/integer_to_radix_digits.sv @@
// Integer to radix digits.
// Request channel (req_valid / req_stall): one unsigned number and a radix per
// transfer. Response channel (rsp_valid / rsp_stall): one ASCII digit per
// transfer, most significant first, rsp_last_digit on the final one. Zero
// gives the single digit '0'. A radix outside 2..36 gives one response with
// rsp_radix_error set, rsp_digit_char 0 and rsp_last_digit set.
// A two-entry queue sits between the request side and the converter, so up to
// two requests are taken while the converter is busy or the receiver stalls.
// A bit-serial restoring divider forms each digit as the remainder of a
// full-width division, storing digits least significant first; each digit is
// then read back from the store, loaded and presented (READ, LOAD, SEND).
// A radix error skips the divider. A stalled response holds its payload and
// the converter waits. Reset (synchronous, active high) empties the queue and
// idles the converter; the digit store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_digits_assert.svh"

module integer_to_radix_digits #(
   parameter int NUMBER_WIDTH = 64,
   parameter int MAX_DIGITS   = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [itrd_pkg::IN_WIDTH-1:0]     req_number_value,
   input  wire logic [itrd_pkg::RADIX_WIDTH-1:0]  req_radix,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [itrd_pkg::CHAR_WIDTH-1:0]        rsp_digit_char,
   output logic                                   rsp_last_digit,
   output logic                                   rsp_radix_error
);

   logic                    q_valid;
   logic                    q_take;
   logic [NUMBER_WIDTH-1:0] q_number;
   itrd_pkg::itrd_cmd_type  q_cmd;

   // accept, classify and queue requests
   itrd_front #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_number_value (req_number_value),
      .req_radix        (req_radix),
      .q_valid          (q_valid),
      .q_take           (q_take),
      .q_number         (q_number),
      .q_cmd            (q_cmd)
   );

   // divide, store digits, then emit them in reverse order
   itrd_back #(
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .MAX_DIGITS   (MAX_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_take          (q_take),
      .q_number        (q_number),
      .q_cmd           (q_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_last_digit  (rsp_last_digit),
      .rsp_radix_error (rsp_radix_error)
   );

   // an error response is always a single, final, blank transfer
   `ITRD_ASSERT_NOW(a_error_form, rsp_valid && rsp_radix_error,
      rsp_last_digit && (rsp_digit_char == itrd_pkg::ERROR_CHAR))

   // a digit response carries a legal character code
   `ITRD_ASSERT_NOW(a_digit_range, rsp_valid && !rsp_radix_error,
      ((rsp_digit_char >= 7'd48) && (rsp_digit_char <= 7'd57)) ||
      ((rsp_digit_char >= 7'd65) && (rsp_digit_char <= 7'd90)))

   // the converter never pops an empty queue
   `ITRD_ASSERT_NOW(a_take_valid, q_take, q_valid)

   // a popped request leaves the converter busy in the following cycle
   `ITRD_ASSERT_NEXT(a_take_busy, q_take, !q_take)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int NUMBER_WIDTH = 64;
   localparam int MAX_DIGITS   = 64;

   // Mask for the bits of the number that the converter actually uses.
   localparam logic [itrd_pkg::IN_WIDTH-1:0] NUMBER_MASK =
      (NUMBER_WIDTH >= itrd_pkg::IN_WIDTH) ? {itrd_pkg::IN_WIDTH{1'b1}}
                                           : ((64'd1 << NUMBER_WIDTH) - 64'd1);

   // A base-2 conversion of a full-width number keeps the block silent until
   // all its digits are divided out. The limit allows for that, plus the long
   // receiver hold below.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 2500;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic [itrd_pkg::CHAR_WIDTH-1:0] digit_char;
      logic                            last_digit;
      logic                            radix_error;
   } digit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   logic [itrd_pkg::IN_WIDTH-1:0]    req_number_value = '0;
   logic [itrd_pkg::RADIX_WIDTH-1:0] req_radix        = '0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   logic [itrd_pkg::CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                             rsp_last_digit;
   logic                             rsp_radix_error;

   // Digits still owed by the block, oldest first.
   digit_type pending_digits[$];

   // Predictor state: digit values least significant first, and the length of
   // the latest conversion.
   logic [itrd_pkg::DIGIT_WIDTH-1:0] digit_store_copy[MAX_DIGITS];
   logic [6:0]                       digit_count_copy = '0;

   int send_idle_pct      = 0;
   int recv_idle_pct      = 0;
   bit long_hold_pending  = 1'b0;
   int hold_left          = 0;

   int mismatch_count     = 0;
   int numbers_sent       = 0;
   int errors_sent        = 0;
   int digits_checked     = 0;
   int input_stall_cycles = 0;
   int quiet_cycles       = 0;

   integer_to_radix_digits #(
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .MAX_DIGITS   (MAX_DIGITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_number_value (req_number_value),
      .req_radix        (req_radix),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit),
      .rsp_radix_error  (rsp_radix_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Work out the digits one number turns into and queue them. Digits are
   // formed least significant first, then queued most significant first.
   function automatic void convert_number(input logic [itrd_pkg::IN_WIDTH-1:0] value,
                                          input logic [itrd_pkg::RADIX_WIDTH-1:0] radix);
      string                            glyphs;
      logic [itrd_pkg::IN_WIDTH-1:0]    rest;
      logic [itrd_pkg::IN_WIDTH-1:0]    base;
      logic [itrd_pkg::DIGIT_WIDTH-1:0] digit_value;
      int                               count;
      digit_type                        item;
      glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
      rest   = value & NUMBER_MASK;
      base   = {{(itrd_pkg::IN_WIDTH-itrd_pkg::RADIX_WIDTH){1'b0}}, radix};
      // A radix out of range gives one flagged result and leaves the store.
      if (radix < itrd_pkg::RADIX_MIN || radix > itrd_pkg::RADIX_MAX) begin
         digit_count_copy = '0;
         item.digit_char  = itrd_pkg::ERROR_CHAR;
         item.last_digit  = 1'b1;
         item.radix_error = 1'b1;
         pending_digits.push_back(item);
         return;
      end
      count = 0;
      // Stop at MAX_DIGITS: higher digits of a too-long number are dropped.
      do begin
         digit_store_copy[count] = itrd_pkg::DIGIT_WIDTH'(rest % base);
         rest = rest / base;
         count++;
      end while (rest != 0 && count < MAX_DIGITS);
      digit_count_copy = 7'(count);
      for (int k = 0; k < count; k++) begin
         digit_value      = digit_store_copy[count - 1 - k];
         item.digit_char  = (digit_value < 36)
                            ? itrd_pkg::CHAR_WIDTH'(glyphs[digit_value])
                            : itrd_pkg::CHAR_WIDTH'(glyphs[0]);
         item.last_digit  = (k + 1 == count);
         item.radix_error = 1'b0;
         pending_digits.push_back(item);
      end
   endfunction

   // Mostly short numbers so that conversions stay quick; a tenth are full
   // width so every bit is exercised.
   function automatic logic [itrd_pkg::IN_WIDTH-1:0] random_number();
      logic [itrd_pkg::IN_WIDTH-1:0] raw;
      int                            pick;
      int                            span;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 70) begin
         span = $urandom_range(16);
      end else if (pick < 90) begin
         span = $urandom_range(40, 17);
      end else begin
         span = itrd_pkg::IN_WIDTH;
      end
      if (span < itrd_pkg::IN_WIDTH) begin
         raw = raw & ((64'd1 << span) - 64'd1);
      end
      return raw;
   endfunction

   // Mostly legal radixes; the rest spread over the whole byte.
   function automatic logic [itrd_pkg::RADIX_WIDTH-1:0] random_radix();
      if ($urandom_range(99) < 85) begin
         return itrd_pkg::RADIX_WIDTH'($urandom_range(itrd_pkg::RADIX_MAX,
                                                      itrd_pkg::RADIX_MIN));
      end
      return itrd_pkg::RADIX_WIDTH'($urandom_range(255));
   endfunction

   // Offer one number and hold it until the block takes it. Entered and left
   // just after a rising edge; the transfer happens at the edge on exit.
   task automatic send_number(input logic [itrd_pkg::IN_WIDTH-1:0] value,
                              input logic [itrd_pkg::RADIX_WIDTH-1:0] radix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_number_value <= value;
      req_radix        <= radix;
      // Sample the handshake mid-cycle, where nothing moves.
      @(negedge clock);
      while (req_stall) begin
         input_stall_cycles++;
         @(negedge clock);
      end
      convert_number(value, radix);
      numbers_sent++;
      if (radix < itrd_pkg::RADIX_MIN || radix > itrd_pkg::RADIX_MAX) begin
         errors_sent++;
      end
      @(posedge clock);
   endtask

   // Drop valid after the last number of a test.
   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every owed digit has arrived, then let the block settle.
   task automatic wait_for_drain();
      while (pending_digits.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_number(64'd0, 8'd2);
      send_number(64'd0, 8'd10);
      send_number(64'd0, 8'd36);
      send_number(64'd1, 8'd2);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 8'd2);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 8'd16);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 8'd10);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 8'd36);
      send_number(64'h8000_0000_0000_0000, 8'd2);
      send_number(64'hAAAA_AAAA_AAAA_AAAA, 8'd3);
      send_number(64'h5555_5555_5555_5555, 8'd7);
      send_number(64'd35, 8'd36);
      send_number(64'd36, 8'd36);
      send_number(64'd1295, 8'd36);
      send_number(64'd9, 8'd10);
      send_number(64'd10, 8'd16);
      send_number(64'd12345, 8'd10);
      // Radix just outside the legal range on both sides, and far outside.
      send_number(64'd77, 8'd0);
      send_number(64'd77, 8'd1);
      send_number(64'd77, 8'd37);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
      send_number(64'd5, 8'h80);
      stop_sending();
      wait_for_drain();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_number(random_number(), random_radix());
      end
      stop_sending();
      wait_for_drain();
   endtask

   // Hold the receiver off for a long stretch while numbers keep coming, so
   // the internal queue fills and the request side stalls.
   task automatic test_backpressure();
      long_hold_pending = 1'b1;
      for (int i = 0; i < 10; i++) begin
         send_number(64'($urandom_range(9999)), 8'd10);
      end
      stop_sending();
      wait_for_drain();
   endtask

   // Receiver: stall at random, or for a counted long stretch on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Check each digit transfer against the oldest owed digit. Outputs are
   // stable mid-cycle; the transfer itself lands on the next rising edge.
   always @(negedge clock) begin : check_digit
      digit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected digit transfer: digit_char %0d last_digit %0d radix_error %0d",
                   rsp_digit_char, rsp_last_digit, rsp_radix_error);
            mismatch_count++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $error("digit_char: expected %0d, got %0d", want.digit_char, rsp_digit_char);
               mismatch_count++;
            end
            if (rsp_last_digit !== want.last_digit) begin
               $error("last_digit: expected %0d, got %0d", want.last_digit, rsp_last_digit);
               mismatch_count++;
            end
            if (rsp_radix_error !== want.radix_error) begin
               $error("radix_error: expected %0d, got %0d",
                      want.radix_error, rsp_radix_error);
               mismatch_count++;
            end
            digits_checked++;
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d digits still owed",
                     quiet_cycles, pending_digits.size());
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Sender lightly idle, receiver mostly stalled.
      send_idle_pct = 14;
      recv_idle_pct = 65;
      test_directed();
      test_random(40);

      // Swap the roles.
      send_idle_pct = 65;
      recv_idle_pct = 14;
      test_random(40);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(30);
      test_backpressure();

      $display("converted %0d numbers (%0d with a bad radix) into %0d checked digits",
               numbers_sent, errors_sent, digits_checked);
      $display("three idling mixes plus one long receiver hold; request side stalled %0d cycles",
               input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
